// ===== src/rta_pkg.sv =====
// shared constants and types for the per-task runtime accounting block
package rta_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int PID_W         = 22;
   localparam int TIME_W        = 64;
   localparam int STATUS_W      = 2;
   localparam int REQ_DATA_W    = 136;
   localparam int RSP_DATA_W    = 216;

   localparam logic KIND_SWITCH = 1'b0;
   localparam logic KIND_EXIT   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_NONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REPORTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EXIT     = 2'd3;

   localparam logic [TIME_W-1:0] US_BIAS  = 64'd24;
   localparam int                US_SHIFT = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PID_W-1:0]    pid;
      logic [TIME_W-1:0]   time_ns;
      logic [SLOT_W-1:0]   slot;
      logic                total_hit;
   } evt_ctl_type;

endpackage

// ===== src/per_task_runtime_accounting.sv =====
// top level of the per-task runtime accounting block
// Each word on the request side is one scheduler event and yields exactly one response word,
// in order. The block takes one event per clock cycle when the response side keeps up; the
// response for an event passes through the input register, table lookup, four conversion
// stages, total update and response register. Both 64-entry task tables are searched in
// parallel, and the run time total is read and rewritten in a single stage with a bypass,
// so back-to-back events for the same task need no stall.
module per_task_runtime_accounting (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // kind
   input  logic                           req_tuser,
   // time_ns, outgoing pid, incoming pid, exit_pid, zero pad
   input  logic [rta_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status
   output logic [rta_pkg::STATUS_W-1:0]   rsp_tuser,
   // event_pid, event_time_ns, run_ns, total_us, zero pad
   output logic [rta_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rta_pkg::*;

   logic                tb_valid, tb_ready;
   evt_ctl_type         tb_ctl;
   logic [TIME_W-1:0]   tb_run;
   logic                cv_valid, cv_ready;
   evt_ctl_type         cv_ctl;
   logic [TIME_W-1:0]   cv_run;
   logic [TIME_W-1:0]   cv_us;
   logic [PID_W-1:0]    rsp_pid;
   logic [TIME_W-1:0]   rsp_time;
   logic [TIME_W-1:0]   rsp_run;
   logic [TIME_W-1:0]   rsp_total;

   rta_table u_table (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_kind     (req_tuser),
      .in_time_ns  (req_tdata[63:0]),
      .in_out_task (req_tdata[85:64]),
      .in_in_task  (req_tdata[107:86]),
      .in_exit_pid (req_tdata[129:108]),
      .out_valid   (tb_valid),
      .out_ready   (tb_ready),
      .out_ctl     (tb_ctl),
      .out_run_ns  (tb_run)
   );

   rta_us_pipe u_us_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (tb_valid),
      .in_ready   (tb_ready),
      .in_ctl     (tb_ctl),
      .in_run_ns  (tb_run),
      .out_valid  (cv_valid),
      .out_ready  (cv_ready),
      .out_ctl    (cv_ctl),
      .out_run_ns (cv_run),
      .out_us     (cv_us)
   );

   rta_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (cv_valid),
      .in_ready     (cv_ready),
      .in_ctl       (cv_ctl),
      .in_run_ns    (cv_run),
      .in_us        (cv_us),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_status   (rsp_tuser),
      .out_pid      (rsp_pid),
      .out_time_ns  (rsp_time),
      .out_run_ns   (rsp_run),
      .out_total_us (rsp_total)
   );

   assign rsp_tdata = {2'b00, rsp_total, rsp_run, rsp_time, rsp_pid};

endmodule

// ===== src/rta_table.sv =====
// input register, start and total key tables, start timestamp memory
module rta_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic                      in_kind,
   input  logic [rta_pkg::TIME_W-1:0] in_time_ns,
   input  logic [rta_pkg::PID_W-1:0]  in_out_task,
   input  logic [rta_pkg::PID_W-1:0]  in_in_task,
   input  logic [rta_pkg::PID_W-1:0]  in_exit_pid,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rta_pkg::evt_ctl_type      out_ctl,
   output logic [rta_pkg::TIME_W-1:0] out_run_ns
);
   import rta_pkg::*;

   logic                      s0_valid_ff;
   logic                      s0_kind_ff;
   logic [TIME_W-1:0]         s0_time_ff;
   logic [PID_W-1:0]          s0_prev_ff;
   logic [PID_W-1:0]          s0_next_ff;
   logic [PID_W-1:0]          s0_exit_ff;

   logic                      s1_valid_ff;
   evt_ctl_type               s1_ctl_ff;
   logic [TIME_W-1:0]         s1_stamp_ff;

   logic [TABLE_ENTRIES-1:0]  sv_ff;
   logic [TABLE_ENTRIES-1:0]  sv_in;
   logic [TABLE_ENTRIES-1:0]  tv_ff;
   logic [TABLE_ENTRIES-1:0]  tv_in;
   logic [PID_W-1:0]          skey_ff [TABLE_ENTRIES];
   logic [PID_W-1:0]          tkey_ff [TABLE_ENTRIES];
   logic [TIME_W-1:0]         stamp_mem [TABLE_ENTRIES];

   logic                      s1_take;
   logic                      s0_fire;
   logic [PID_W-1:0]          key_a;
   logic [TABLE_ENTRIES-1:0]  s_match_a;
   logic [TABLE_ENTRIES-1:0]  s_match_n;
   logic [TABLE_ENTRIES-1:0]  t_match;
   logic [SLOT_W-1:0]         s_idx;
   logic [SLOT_W-1:0]         n_idx;
   logic [SLOT_W-1:0]         t_idx;
   logic [SLOT_W-1:0]         s_free_idx;
   logic [SLOT_W-1:0]         t_free_idx;
   logic                      s_hit;
   logic                      n_hit;
   logic                      t_hit;
   logic                      s_free;
   logic                      t_free;
   logic                      s_clr;
   logic                      t_clr;
   logic                      s_ins;
   logic                      t_alloc;
   logic [SLOT_W-1:0]         s_ins_idx;
   evt_ctl_type               ctl;

   assign s1_take  = !s1_valid_ff || out_ready;
   assign s0_fire  = s0_valid_ff && s1_take;
   assign in_ready = !s0_valid_ff || s1_take;
   assign key_a    = (s0_kind_ff == KIND_EXIT) ? s0_exit_ff : s0_prev_ff;

   // parallel match and lowest free slot search
   always_comb begin
      s_idx      = '0;
      n_idx      = '0;
      t_idx      = '0;
      s_free_idx = '0;
      t_free_idx = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         s_match_a[i] = sv_ff[i] && (skey_ff[i] == key_a);
         s_match_n[i] = sv_ff[i] && (skey_ff[i] == s0_next_ff);
         t_match[i]   = tv_ff[i] && (tkey_ff[i] == key_a);
      end
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (s_match_a[i]) begin
            s_idx = SLOT_W'(i);
         end
         if (s_match_n[i]) begin
            n_idx = SLOT_W'(i);
         end
         if (t_match[i]) begin
            t_idx = SLOT_W'(i);
         end
         if (!sv_ff[i]) begin
            s_free_idx = SLOT_W'(i);
         end
         if (!tv_ff[i]) begin
            t_free_idx = SLOT_W'(i);
         end
      end
      s_hit  = |s_match_a;
      n_hit  = |s_match_n;
      t_hit  = |t_match;
      s_free = !(&sv_ff);
      t_free = !(&tv_ff);
   end

   // event decision
   always_comb begin
      s_clr     = 1'b0;
      t_clr     = 1'b0;
      s_ins     = 1'b0;
      t_alloc   = 1'b0;
      s_ins_idx = n_hit ? n_idx : s_free_idx;
      ctl       = '0;
      if (s0_kind_ff == KIND_EXIT) begin
         ctl.status = ST_EXIT;
         ctl.pid    = s0_exit_ff;
         s_clr      = s_hit;
         t_clr      = t_hit;
      end else begin
         if (s_hit) begin
            ctl.pid     = s0_prev_ff;
            ctl.time_ns = s0_time_ff;
            if (t_hit) begin
               ctl.status    = ST_REPORTED;
               ctl.slot      = t_idx;
               ctl.total_hit = 1'b1;
            end else if (t_free) begin
               ctl.status = ST_REPORTED;
               ctl.slot   = t_free_idx;
               t_alloc    = 1'b1;
            end else begin
               ctl.status = ST_FULL;
            end
         end else begin
            ctl.status = ST_NONE;
         end
         s_ins = (ctl.status != ST_FULL) && (n_hit || s_free);
      end
   end

   always_comb begin
      sv_in = sv_ff;
      tv_in = tv_ff;
      if (s0_fire) begin
         if (s_clr) begin
            sv_in[s_idx] = 1'b0;
         end
         if (s_ins) begin
            sv_in[s_ins_idx] = 1'b1;
         end
         if (t_clr) begin
            tv_in[t_idx] = 1'b0;
         end
         if (t_alloc) begin
            tv_in[ctl.slot] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         sv_ff       <= '0;
         tv_ff       <= '0;
      end else begin
         s0_valid_ff <= in_ready ? in_valid : s0_valid_ff;
         s1_valid_ff <= s1_take ? s0_valid_ff : s1_valid_ff;
         sv_ff       <= sv_in;
         tv_ff       <= tv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s0_kind_ff <= in_kind;
         s0_time_ff <= in_time_ns;
         s0_prev_ff <= in_out_task;
         s0_next_ff <= in_in_task;
         s0_exit_ff <= in_exit_pid;
      end
      if (s1_take) begin
         s1_ctl_ff <= ctl;
      end
      if (s0_fire && s_ins) begin
         skey_ff[s_ins_idx] <= s0_next_ff;
      end
      if (s0_fire && t_alloc) begin
         tkey_ff[ctl.slot] <= s0_prev_ff;
      end
   end

   // start stamp memory, read before write
   always_ff @(posedge clock) begin
      if (s0_fire) begin
         s1_stamp_ff <= stamp_mem[s_idx];
      end
      if (s0_fire && s_ins) begin
         stamp_mem[s_ins_idx] <= s0_time_ff;
      end
   end

   assign out_valid  = s1_valid_ff;
   assign out_ctl    = s1_ctl_ff;
   assign out_run_ns = (s1_ctl_ff.status == ST_REPORTED || s1_ctl_ff.status == ST_FULL)
                       ? (s1_ctl_ff.time_ns - s1_stamp_ff) : '0;

   a_exit_clears_start: assert property (@(posedge clock) disable iff (reset)
      (s0_fire && s0_kind_ff == KIND_EXIT && s_hit) |=> !sv_ff[$past(s_idx)])
      else $error("exited task still holds a start entry");

   a_alloc_sets_total: assert property (@(posedge clock) disable iff (reset)
      (s0_fire && t_alloc) |=> tv_ff[$past(ctl.slot)])
      else $error("new total entry not marked valid");

   a_switch_keeps_totals: assert property (@(posedge clock) disable iff (reset)
      (s0_fire && s0_kind_ff == KIND_SWITCH)
      |=> $countones(tv_ff) >= $past($countones(tv_ff)))
      else $error("switch event dropped a total entry");

endmodule

// ===== src/rta_us_pipe.sv =====
// four stage shift-add nanosecond to microsecond conversion
module rta_us_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rta_pkg::evt_ctl_type      in_ctl,
   input  logic [rta_pkg::TIME_W-1:0] in_run_ns,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rta_pkg::evt_ctl_type      out_ctl,
   output logic [rta_pkg::TIME_W-1:0] out_run_ns,
   output logic [rta_pkg::TIME_W-1:0] out_us
);
   import rta_pkg::*;

   logic              a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   evt_ctl_type       a_ctl_ff, b_ctl_ff, c_ctl_ff, d_ctl_ff;
   logic [TIME_W-1:0] a_n_ff, b_n_ff, c_n_ff, d_n_ff;
   logic [TIME_W-1:0] b_t_ff;
   logic [TIME_W-1:0] c_q_ff, d_q_ff;
   logic [TIME_W-1:0] d_r_ff;

   logic              a_take, b_take, c_take, d_take;
   logic [TIME_W-1:0] t_val;
   logic [TIME_W-1:0] q_sum;
   logic [TIME_W-1:0] q_val;
   logic [TIME_W-1:0] r_val;
   logic [TIME_W-1:0] r_bias;

   assign d_take   = !d_valid_ff || out_ready;
   assign c_take   = !c_valid_ff || d_take;
   assign b_take   = !b_valid_ff || c_take;
   assign a_take   = !a_valid_ff || b_take;
   assign in_ready = a_take;

   assign t_val  = (a_n_ff >> 7) + (a_n_ff >> 8) + (a_n_ff >> 12);
   assign q_sum  = (b_n_ff >> 1) + b_t_ff + (b_n_ff >> 15) + (b_t_ff >> 11) + (b_t_ff >> 14);
   assign q_val  = q_sum >> 9;
   // n - 1000*q with 1000 = 1024 - 16 - 8
   assign r_val  = c_n_ff - (c_q_ff << 10) + (c_q_ff << 4) + (c_q_ff << 3);
   assign r_bias = d_r_ff + US_BIAS;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_take ? in_valid : a_valid_ff;
         b_valid_ff <= b_take ? a_valid_ff : b_valid_ff;
         c_valid_ff <= c_take ? b_valid_ff : c_valid_ff;
         d_valid_ff <= d_take ? c_valid_ff : d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take) begin
         a_ctl_ff <= in_ctl;
         a_n_ff   <= in_run_ns;
      end
      if (b_take) begin
         b_ctl_ff <= a_ctl_ff;
         b_n_ff   <= a_n_ff;
         b_t_ff   <= t_val;
      end
      if (c_take) begin
         c_ctl_ff <= b_ctl_ff;
         c_n_ff   <= b_n_ff;
         c_q_ff   <= q_val;
      end
      if (d_take) begin
         d_ctl_ff <= c_ctl_ff;
         d_n_ff   <= c_n_ff;
         d_q_ff   <= c_q_ff;
         d_r_ff   <= r_val;
      end
   end

   assign out_valid  = d_valid_ff;
   assign out_ctl    = d_ctl_ff;
   assign out_run_ns = d_n_ff;
   assign out_us     = d_q_ff + (r_bias >> US_SHIFT);

endmodule

// ===== src/rta_accum.sv =====
// runtime total memory with read-modify-write and the result register
module rta_accum (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  rta_pkg::evt_ctl_type        in_ctl,
   input  logic [rta_pkg::TIME_W-1:0]   in_run_ns,
   input  logic [rta_pkg::TIME_W-1:0]   in_us,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [rta_pkg::STATUS_W-1:0] out_status,
   output logic [rta_pkg::PID_W-1:0]    out_pid,
   output logic [rta_pkg::TIME_W-1:0]   out_time_ns,
   output logic [rta_pkg::TIME_W-1:0]   out_run_ns,
   output logic [rta_pkg::TIME_W-1:0]   out_total_us
);
   import rta_pkg::*;

   logic                e_valid_ff;
   evt_ctl_type         e_ctl_ff;
   logic [TIME_W-1:0]   e_run_ff;
   logic [TIME_W-1:0]   e_us_ff;
   logic [TIME_W-1:0]   e_rd_ff;

   logic                o_valid_ff;
   logic [STATUS_W-1:0] o_status_ff;
   logic [PID_W-1:0]    o_pid_ff;
   logic [TIME_W-1:0]   o_time_ff;
   logic [TIME_W-1:0]   o_run_ff;
   logic [TIME_W-1:0]   o_total_ff;

   logic [TIME_W-1:0]   total_mem [TABLE_ENTRIES];

   logic                o_take;
   logic                e_take;
   logic                wr_en;
   logic [TIME_W-1:0]   sum;

   assign o_take   = !o_valid_ff || out_ready;
   assign e_take   = !e_valid_ff || o_take;
   assign in_ready = e_take;
   assign sum      = e_us_ff + (e_ctl_ff.total_hit ? e_rd_ff : '0);
   assign wr_en    = e_valid_ff && o_take && (e_ctl_ff.status == ST_REPORTED);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= e_take ? in_valid : e_valid_ff;
         o_valid_ff <= o_take ? e_valid_ff : o_valid_ff;
      end
   end

   // bypass the word written at the same edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         total_mem[e_ctl_ff.slot] <= sum;
      end
      if (e_take) begin
         e_rd_ff <= (wr_en && (e_ctl_ff.slot == in_ctl.slot)) ? sum : total_mem[in_ctl.slot];
      end
   end

   always_ff @(posedge clock) begin
      if (e_take) begin
         e_ctl_ff <= in_ctl;
         e_run_ff <= in_run_ns;
         e_us_ff  <= in_us;
      end
      if (o_take) begin
         o_status_ff <= e_ctl_ff.status;
         o_pid_ff    <= e_ctl_ff.pid;
         o_time_ff   <= e_ctl_ff.time_ns;
         o_run_ff    <= e_run_ff;
         o_total_ff  <= (e_ctl_ff.status == ST_REPORTED) ? sum : '0;
      end
   end

   assign out_valid    = o_valid_ff;
   assign out_status   = o_status_ff;
   assign out_pid      = o_pid_ff;
   assign out_time_ns  = o_time_ff;
   assign out_run_ns   = o_run_ff;
   assign out_total_us = o_total_ff;

endmodule
